@@ rtl/bba_pkg.sv @@
package bba_pkg;

	localparam int HEAP_LOG2_DEF = 16;
	localparam int LEAF_LOG2_DEF = 4;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BIG   = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	// controller -> datapath strobes
	typedef struct packed {
		logic    load;
		logic    init_step;
		logic    set_err;
		status_t err;
		logic    scan_start;
		logic    scan_rd;
		logic    take;
		logic    scan_next;
		logic    split_rd;
		logic    split_wr;
		logic    find_start;
		logic    find_rd;
		logic    find_up;
		logic    find_done;
		logic    query_ok;
		logic    set_size;
		logic    merge_rd;
		logic    merge_step;
		logic    out_load;
	} bba_cmd_t;

	// datapath -> controller flags
	typedef struct packed {
		op_t  op;
		logic init_last;
		logic too_large;
		logic any_fit;
		logic range_bad;
		logic scan_hit;
		logic split_more;
		logic split_hit;
		logic find_top;
		logic misaligned;
		logic free_hit;
		logic merge_go;
		logic out_free;
	} bba_sts_t;

endpackage

@@ rtl/buddy_block_allocator.sv @@
// Binary buddy allocator over a 2^HEAP_LOG2-byte heap with 2^LEAF_LOG2-byte leaves. After reset
// a clearing pass over 2^(D+1-WL) free-bitmap words (256 at the defaults; D = HEAP_LOG2-LEAF_LOG2,
// WL = 5 for D >= 6) writes the free and split bitmaps while s_tready stays low. Requests are handled
// one at a time; the next one is taken while the previous result waits in the output register.
// Both bitmaps live in RAMs of 2^WL-bit words (32 at the defaults) with a registered read, so
// every bit update is a read-modify-write. Allocate scans the bitmap words at the chosen level,
// then splits down to the target level; free and query walk up the tree to find the block's
// level, and free then merges with free buddies. Per-level free counters give the largest free
// block without a scan.
module buddy_block_allocator #(
	parameter int HEAP_LOG2 = bba_pkg::HEAP_LOG2_DEF,
	parameter int LEAF_LOG2 = bba_pkg::LEAF_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // request_size[16:0], block_offset[32:17], zero fill
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // result_offset[15:0], result_size[32:16], largest_free[49:33]
	output logic [1:0]  m_tuser   // status
);

	import bba_pkg::*;

	bba_cmd_t    cmd;
	bba_sts_t    sts;
	logic [15:0] out_offset;
	logic [16:0] out_size, out_largest;

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	bba_dp #(.HEAP_LOG2(HEAP_LOG2), .LEAF_LOG2(LEAF_LOG2)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_op(s_tuser), .in_req(s_tdata[16:0]), .in_off(s_tdata[32:17]),
		.cmd(cmd), .sts(sts),
		.out_ready(m_tready), .out_valid(m_tvalid), .out_status(m_tuser),
		.out_offset(out_offset), .out_size(out_size), .out_largest(out_largest)
	);

	assign m_tdata = {6'b0, out_largest, out_size, out_offset};

endmodule

@@ rtl/bba_ram.sv @@
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bba_ctrl.sv @@
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bba_pkg::bba_sts_t sts,
	output bba_pkg::bba_cmd_t cmd
);

	import bba_pkg::*;

	typedef enum logic [13:0] {
		S_INIT      = 14'b00000000000001,
		S_IDLE      = 14'b00000000000010,
		S_DECODE    = 14'b00000000000100,
		S_SCAN_RD   = 14'b00000000001000,
		S_SCAN_CHK  = 14'b00000000010000,
		S_SPLIT_RD  = 14'b00000000100000,
		S_SPLIT_WR  = 14'b00000001000000,
		S_FIND_RD   = 14'b00000010000000,
		S_FIND_CHK  = 14'b00000100000000,
		S_CHECK_RD  = 14'b00001000000000,
		S_CHECK_CHK = 14'b00010000000000,
		S_MERGE_RD  = 14'b00100000000000,
		S_MERGE_WR  = 14'b01000000000000,
		S_DONE      = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.err = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_ALLOC: begin
						if (sts.too_large) begin
							cmd.set_err = 1'b1;
							cmd.err     = ST_BIG;
							state_d     = S_DONE;
						end else if (!sts.any_fit) begin
							cmd.set_err = 1'b1;
							cmd.err     = ST_NOFIT;
							state_d     = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN_RD;
						end
					end
					OP_FREE, OP_QUERY: begin
						if (sts.range_bad) begin
							cmd.set_err = 1'b1;
							cmd.err     = ST_BAD;
							state_d     = S_DONE;
						end else begin
							cmd.find_start = 1'b1;
							state_d        = S_FIND_RD;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (sts.scan_hit) begin
					cmd.take = 1'b1;
					state_d  = S_SPLIT_RD;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_SPLIT_RD: begin
				if (sts.split_more) begin
					cmd.split_rd = 1'b1;
					state_d      = S_SPLIT_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SPLIT_WR: begin
				cmd.split_wr = 1'b1;
				state_d      = S_SPLIT_RD;
			end
			S_FIND_RD: begin
				cmd.find_rd = 1'b1;
				state_d     = S_FIND_CHK;
			end
			S_FIND_CHK: begin
				if (sts.split_hit || sts.find_top) begin
					cmd.find_done = 1'b1;
					state_d       = S_CHECK_RD;
				end else begin
					cmd.find_up = 1'b1;
					state_d     = S_FIND_RD;
				end
			end
			S_CHECK_RD: begin
				if (sts.misaligned) begin
					cmd.set_err = 1'b1;
					cmd.err     = ST_BAD;
					state_d     = S_DONE;
				end else begin
					cmd.merge_rd = 1'b1;
					state_d      = S_CHECK_CHK;
				end
			end
			S_CHECK_CHK: begin
				if (sts.free_hit) begin
					cmd.set_err = 1'b1;
					cmd.err     = ST_BAD;
					state_d     = S_DONE;
				end else if (sts.op == OP_QUERY) begin
					cmd.query_ok = 1'b1;
					cmd.set_size = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.set_size   = 1'b1;
					cmd.merge_step = 1'b1;
					state_d        = sts.merge_go ? S_MERGE_RD : S_DONE;
				end
			end
			S_MERGE_RD: begin
				cmd.merge_rd = 1'b1;
				state_d      = S_MERGE_WR;
			end
			S_MERGE_WR: begin
				cmd.merge_step = 1'b1;
				state_d        = sts.merge_go ? S_MERGE_RD : S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

@@ rtl/bba_dp.sv @@
module bba_dp #(
	parameter int HEAP_LOG2 = bba_pkg::HEAP_LOG2_DEF,
	parameter int LEAF_LOG2 = bba_pkg::LEAF_LOG2_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        in_op,
	input  logic [16:0]       in_req,
	input  logic [15:0]       in_off,
	input  bba_pkg::bba_cmd_t cmd,
	output bba_pkg::bba_sts_t sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [1:0]        out_status,
	output logic [15:0]       out_offset,
	output logic [16:0]       out_size,
	output logic [16:0]       out_largest
);

	import bba_pkg::*;

	localparam int D   = HEAP_LOG2 - LEAF_LOG2;
	localparam int WL  = (D >= 6) ? 5 : D - 1;
	localparam int W   = 1 << WL;
	localparam int NW  = D + 1;
	localparam int FAW = D + 1 - WL;
	localparam int SAW = D - WL;
	localparam int LW  = $clog2(D + 1);
	localparam int CW  = D + 1;
	localparam int OW  = (HEAP_LOG2 > 16) ? HEAP_LOG2 : 16;
	localparam int RW  = (HEAP_LOG2 + 1 > 17) ? HEAP_LOG2 + 1 : 17;

	function automatic logic [16:0] size17(int sh);
		return 17'(1) << sh;
	endfunction

	function automatic logic [W-1:0] level_mask(logic [LW-1:0] l);
		logic [W-1:0] m;
		m = '1;
		if (int'(l) < WL) begin
			for (int i = 0; i < W; i++) begin
				m[i] = ((i >> int'(l)) == 1);
			end
		end
		return m;
	endfunction

	function automatic logic [15:0] node_off(logic [NW-1:0] n, logic [LW-1:0] l);
		logic [OW-1:0] k;
		k = OW'(n) & ~(OW'(1) << l);
		k = k << (HEAP_LOG2 - int'(l));
		return k[15:0];
	endfunction

	op_t             op_q;
	logic [OW-1:0]   off_q;
	logic            too_large_q, range_bad_q;
	logic [LW-1:0]   tgt_q, lvl_q;
	logic [NW-1:0]   node_q;
	logic [FAW-1:0]  word_q;
	status_t         status_q;
	logic [15:0]     roff_q;
	logic [16:0]     rsize_q;
	logic [CW-1:0]   cnt_q [D+1];
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [15:0]     out_offset_q;
	logic [16:0]     out_size_q, out_largest_q;

	logic            f_we, f_re, s_we, s_re;
	logic [FAW-1:0]  f_waddr, f_raddr;
	logic [SAW-1:0]  s_waddr, s_raddr;
	logic [W-1:0]    f_wdata, f_rdata, s_wdata, s_rdata;

	bba_ram #(.WIDTH(W), .DEPTH(1 << FAW)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata)
	);

	bba_ram #(.WIDTH(W), .DEPTH(1 << SAW)) u_split_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	// node neighbors (heap numbering from 1, children 2n and 2n+1)
	logic [NW-1:0] right_n, buddy_n, parent_n, take_n, found_n;
	logic [W-1:0]  scan_bits;
	logic [WL-1:0] low_bit;
	logic [LW-1:0] fit_lvl, top_lvl, found_lvl;
	logic          any_fit, any_free;
	logic [OW-1:0] in_off_w, align_mask;
	logic [4:0]    req_log2;
	int            cl;

	assign right_n  = {node_q[NW-2:0], 1'b1};
	assign buddy_n  = {node_q[NW-1:1], ~node_q[0]};
	assign parent_n = node_q >> 1;
	assign scan_bits = f_rdata & level_mask(lvl_q);
	assign take_n   = {word_q, low_bit};
	assign in_off_w = OW'(in_off);
	assign found_lvl = sts.split_hit ? lvl_q : '0;
	assign found_n  = NW'(off_q >> (HEAP_LOG2 - int'(found_lvl))) | (NW'(1) << found_lvl);
	assign align_mask = (OW'(1) << (HEAP_LOG2 - int'(lvl_q))) - OW'(1);

	always_comb begin
		low_bit = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (scan_bits[i]) low_bit = WL'(i);
		end
	end

	// deepest level at or above the target that has a free block; shallowest free level
	always_comb begin
		fit_lvl  = '0;
		any_fit  = 1'b0;
		top_lvl  = '0;
		any_free = 1'b0;
		for (int l = 0; l <= D; l++) begin
			if (cnt_q[l] != '0 && l <= int'(tgt_q)) begin
				fit_lvl = LW'(l);
				any_fit = 1'b1;
			end
		end
		for (int l = D; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				top_lvl  = LW'(l);
				any_free = 1'b1;
			end
		end
	end

	always_comb begin
		cl = 0;
		for (int i = 0; i < 17; i++) begin
			if ((17'(1) << i) < in_req) cl = i + 1;
		end
		if (cl < LEAF_LOG2) cl = LEAF_LOG2;
		if (cl > HEAP_LOG2) cl = HEAP_LOG2;
		req_log2 = 5'(cl);
	end

	always_comb begin
		sts.op         = op_q;
		sts.init_last  = &word_q;
		sts.too_large  = too_large_q;
		sts.any_fit    = any_fit;
		sts.range_bad  = range_bad_q;
		sts.scan_hit   = |scan_bits;
		sts.split_more = lvl_q < tgt_q;
		sts.split_hit  = s_rdata[node_q[WL-1:0]];
		sts.find_top   = (lvl_q == LW'(1));
		sts.misaligned = (off_q & align_mask) != '0;
		sts.free_hit   = f_rdata[node_q[WL-1:0]];
		sts.merge_go   = (lvl_q != '0) && f_rdata[buddy_n[WL-1:0]];
		sts.out_free   = !out_valid_q || out_ready;
	end

	// memory ports
	always_comb begin
		f_we    = 1'b0;
		f_waddr = word_q;
		f_wdata = '0;
		f_re    = 1'b0;
		f_raddr = word_q;
		s_we    = 1'b0;
		s_waddr = node_q[NW-2:WL];
		s_wdata = '0;
		s_re    = 1'b0;
		s_raddr = node_q[NW-2:WL];
		if (cmd.init_step) begin
			f_we    = 1'b1;
			f_wdata = (word_q == '0) ? W'(2) : '0;
			s_we    = !word_q[FAW-1];
			s_waddr = word_q[SAW-1:0];
		end
		if (cmd.scan_rd) f_re = 1'b1;
		if (cmd.take) begin
			f_we    = 1'b1;
			f_wdata = f_rdata & ~(W'(1) << low_bit);
		end
		if (cmd.split_rd) begin
			f_re    = 1'b1;
			f_raddr = right_n[NW-1:WL];
			s_re    = 1'b1;
		end
		if (cmd.split_wr) begin
			f_we    = 1'b1;
			f_waddr = right_n[NW-1:WL];
			f_wdata = f_rdata | (W'(1) << right_n[WL-1:0]);
			s_we    = 1'b1;
			s_wdata = s_rdata | (W'(1) << node_q[WL-1:0]);
		end
		if (cmd.find_rd) s_re = 1'b1;
		if (cmd.merge_rd) begin
			f_re    = 1'b1;
			f_raddr = node_q[NW-1:WL];
			s_re    = 1'b1;
			s_raddr = parent_n[NW-2:WL];
		end
		if (cmd.merge_step) begin
			f_we    = 1'b1;
			f_waddr = node_q[NW-1:WL];
			if (sts.merge_go) begin
				f_wdata = f_rdata & ~(W'(1) << buddy_n[WL-1:0]);
				s_we    = 1'b1;
				s_waddr = parent_n[NW-2:WL];
				s_wdata = s_rdata & ~(W'(1) << parent_n[WL-1:0]);
			end else begin
				f_wdata = f_rdata | (W'(1) << node_q[WL-1:0]);
			end
		end
	end

	// free block count per level
	logic          cnt_inc, cnt_dec;
	logic [LW-1:0] inc_lvl;

	assign cnt_dec = cmd.take || (cmd.merge_step && sts.merge_go);
	assign cnt_inc = cmd.split_wr || (cmd.merge_step && !sts.merge_go);
	assign inc_lvl = cmd.split_wr ? lvl_q + LW'(1) : lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= D; l++) begin
				cnt_q[l] <= (l == 0) ? CW'(1) : '0;
			end
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int l = 0; l <= D; l++) begin
				if (cnt_dec && lvl_q == LW'(l)) cnt_q[l] <= cnt_q[l] - CW'(1);
				else if (cnt_inc && inc_lvl == LW'(l)) cnt_q[l] <= cnt_q[l] + CW'(1);
			end
			if (cmd.init_step || cmd.scan_next) word_q <= word_q + FAW'(1);
			if (cmd.scan_start) begin
				word_q <= (int'(fit_lvl) >= WL) ? (FAW'(1) << (int'(fit_lvl) - WL)) : '0;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op_t'(in_op);
			off_q       <= in_off_w;
			too_large_q <= RW'(in_req) > (RW'(1) << HEAP_LOG2);
			range_bad_q <= (in_off_w >> HEAP_LOG2) != '0;
			tgt_q       <= LW'(HEAP_LOG2 - int'(req_log2));
			status_q    <= ST_OK;
			roff_q      <= '0;
			rsize_q     <= '0;
		end
		if (cmd.set_err) status_q <= cmd.err;
		if (cmd.scan_start) lvl_q <= fit_lvl;
		if (cmd.take) begin
			node_q  <= take_n;
			roff_q  <= node_off(take_n, lvl_q);
			rsize_q <= size17(HEAP_LOG2 - int'(tgt_q));
		end
		if (cmd.split_wr) begin
			node_q <= {node_q[NW-2:0], 1'b0};
			lvl_q  <= lvl_q + LW'(1);
		end
		if (cmd.find_start) begin
			node_q <= {1'b1, off_q[HEAP_LOG2-1:LEAF_LOG2]} >> 1;
			lvl_q  <= LW'(D);
		end
		if (cmd.find_up) begin
			node_q <= parent_n;
			lvl_q  <= lvl_q - LW'(1);
		end
		if (cmd.find_done) begin
			node_q <= found_n;
			lvl_q  <= found_lvl;
		end
		if (cmd.set_size) rsize_q <= size17(HEAP_LOG2 - int'(lvl_q));
		if (cmd.query_ok) roff_q <= off_q[15:0];
		if (cmd.merge_step) begin
			if (sts.merge_go) begin
				node_q <= parent_n;
				lvl_q  <= lvl_q - LW'(1);
			end else begin
				roff_q <= node_off(node_q, lvl_q);
			end
		end
		if (cmd.out_load) begin
			out_status_q  <= status_q;
			out_offset_q  <= roff_q;
			out_size_q    <= rsize_q;
			out_largest_q <= any_free ? size17(HEAP_LOG2 - int'(top_lvl)) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_offset  = out_offset_q;
	assign out_size    = out_size_q;
	assign out_largest = out_largest_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import bba_pkg::*;

	localparam int HEAP_LOG2 = HEAP_LOG2_DEF;
	localparam int LEAF_LOG2 = LEAF_LOG2_DEF;
	localparam int DEPTH = HEAP_LOG2 - LEAF_LOG2;
	localparam int NODES = 1 << (DEPTH + 1);
	localparam int INNER = 1 << DEPTH;
	localparam int HEAP_BYTES = 1 << HEAP_LOG2;
	localparam int N_RANDOM = 1000;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		status_t     status;
		logic [15:0] offset;
		logic [16:0] size;
		logic [16:0] largest;
	} alloc_result_t;

	typedef struct {
		op_t           op;
		logic [16:0]   req;
		logic [15:0]   off;
		bit            typed;
		alloc_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	buddy_block_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	bit split_bits [INNER];
	bit free_bits [NODES];
	alloc_result_t pending_results [$];
	int unsigned live_blocks [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stall_free = 1'b0;

	function automatic int lvl_first(int lvl);
		return (1 << lvl) - 1;
	endfunction

	function automatic logic [16:0] largest_free_block();
		for (int lvl = 0; lvl <= DEPTH; lvl++)
			for (int k = 0; k < (1 << lvl); k++)
				if (free_bits[lvl_first(lvl) + k])
					return 17'(1 << (HEAP_LOG2 - lvl));
		return '0;
	endfunction

	function automatic alloc_result_t heap_update(op_t op, logic [16:0] req, logic [15:0] off);
		alloc_result_t r;
		int c, target, found, k, n, l, leaf, buddy, sz;
		r = '{ST_OK, 16'd0, 17'd0, 17'd0};
		if (op == OP_ALLOC) begin
			if (req > HEAP_BYTES) begin
				r.status = ST_BIG;
			end else begin
				c = 0;
				while ((1 << c) < req)
					c++;
				if (c < LEAF_LOG2)
					c = LEAF_LOG2;
				target = HEAP_LOG2 - c;
				found = -1;
				k = 0;
				for (int lv = target; lv >= 0 && found < 0; lv--)
					for (int j = 0; j < (1 << lv); j++)
						if (free_bits[lvl_first(lv) + j]) begin
							found = lv;
							k = j;
							break;
						end
				if (found < 0) begin
					r.status = ST_NOFIT;
				end else begin
					l = found;
					n = lvl_first(l) + k;
					r.offset = 16'(k << (HEAP_LOG2 - l));
					free_bits[n] = 1'b0;
					while (l < target) begin
						split_bits[n] = 1'b1;
						free_bits[2 * n + 2] = 1'b1;
						n = 2 * n + 1;
						l++;
					end
					r.size = 17'(1 << (HEAP_LOG2 - target));
				end
			end
		end else if (op == OP_FREE || op == OP_QUERY) begin
			// offsets are 16 bits, so always inside the default heap
			leaf = off >> LEAF_LOG2;
			n = lvl_first(DEPTH) + leaf;
			l = 0;
			for (int lv = DEPTH; lv > 0; lv--) begin
				if (split_bits[(n - 1) >> 1]) begin
					l = lv;
					break;
				end
				n = (n - 1) >> 1;
			end
			sz = 1 << (HEAP_LOG2 - l);
			n = lvl_first(l) + (off >> (HEAP_LOG2 - l));
			if ((off & (sz - 1)) != 0 || free_bits[n]) begin
				r.status = ST_BAD;
			end else if (op == OP_QUERY) begin
				r.offset = off;
				r.size = 17'(sz);
			end else begin
				free_bits[n] = 1'b1;
				while (l > 0) begin
					buddy = (n & 1) ? n + 1 : n - 1;
					if (!free_bits[buddy])
						break;
					free_bits[n] = 1'b0;
					free_bits[buddy] = 1'b0;
					n = (n - 1) >> 1;
					l--;
					split_bits[n] = 1'b0;
					free_bits[n] = 1'b1;
				end
				r.offset = 16'((n - lvl_first(l)) << (HEAP_LOG2 - l));
				r.size = 17'(sz);
			end
		end
		r.largest = largest_free_block();
		return r;
	endfunction

	// one transfer on the request side; valid stays high across zero gaps
	task automatic send_request(op_t op, logic [16:0] req, logic [15:0] off,
			bit typed, alloc_result_t typed_res);
		alloc_result_t r;
		int gap;
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {7'd0, off, req};
		do @(posedge clk); while (!s_tready);
		r = heap_update(op, req, off);
		pending_results.push_back(typed ? typed_res : r);
		if (op == OP_ALLOC && r.status == ST_OK)
			live_blocks.push_back(r.offset);
		if (op == OP_FREE && r.status == ST_OK)
			foreach (live_blocks[i])
				if (live_blocks[i] == off) begin
					live_blocks.delete(i);
					break;
				end
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// response side stalls
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_free <= ~stall_free;
		if (stall_free)
			m_tready <= 1'b1;
		else if ($urandom_range(0, 29) == 0)
			m_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0)
			m_tready <= ~m_tready;
	end

	always @(posedge clk) begin
		alloc_result_t got, want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			got = '{status_t'(m_tuser), m_tdata[15:0], m_tdata[32:16], m_tdata[49:33]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d off=%h size=%h lf=%h got st=%0d off=%h size=%h lf=%h",
							want.status, want.offset, want.size, want.largest,
							got.status, got.offset, got.size, got.largest);
				end
			end
		end
	end

	stim_row_t rows [$];

	initial begin
		op_t         op;
		logic [16:0] req;
		logic [15:0] off;
		int          pick;
		int          wait_cnt;
		for (int i = 0; i < INNER; i++) split_bits[i] = 1'b0;
		for (int i = 0; i < NODES; i++) free_bits[i] = 1'b0;
		free_bits[0] = 1'b1;

		rows = '{
			'{OP_ALLOC, 17'd0,     16'd0,     1, '{ST_OK,  16'd0, 17'd16,    17'd32768}},
			'{OP_ALLOC, 17'd65537, 16'd0,     1, '{ST_BIG, 16'd0, 17'd0,     17'd32768}},
			'{OP_ALLOC, 17'h1FFFF, 16'd0,     1, '{ST_BIG, 16'd0, 17'd0,     17'd32768}},
			'{OP_FREE,  17'd0,     16'd8,     1, '{ST_BAD, 16'd0, 17'd0,     17'd32768}},
			'{OP_QUERY, 17'd0,     16'd0,     1, '{ST_OK,  16'd0, 17'd16,    17'd32768}},
			'{OP_QUERY, 17'd0,     16'd16,    1, '{ST_BAD, 16'd0, 17'd0,     17'd32768}},
			'{OP_FREE,  17'd0,     16'd0,     1, '{ST_OK,  16'd0, 17'd16,    17'd65536}},
			'{OP_FREE,  17'd0,     16'd0,     1, '{ST_BAD, 16'd0, 17'd0,     17'd65536}},
			'{OP_ALLOC, 17'd65536, 16'd0,     1, '{ST_OK,  16'd0, 17'd65536, 17'd0}},
			'{OP_ALLOC, 17'd1,     16'd0,     1, '{ST_NOFIT, 16'd0, 17'd0,   17'd0}},
			'{OP_QUERY, 17'd0,     16'hFFFF,  1, '{ST_BAD, 16'd0, 17'd0,     17'd0}},
			'{OP_FREE,  17'd0,     16'd0,     1, '{ST_OK,  16'd0, 17'd65536, 17'd65536}},
			'{OP_NOP,   17'h1FFFF, 16'hFFFF,  1, '{ST_OK,  16'd0, 17'd0,     17'd65536}},
			'{OP_ALLOC, 17'd1,     16'd0,     0, '0},
			'{OP_ALLOC, 17'd17,    16'd0,     0, '0},
			'{OP_ALLOC, 17'd100,   16'd0,     0, '0},
			'{OP_ALLOC, 17'd16,    16'd0,     0, '0},
			'{OP_ALLOC, 17'd32768, 16'd0,     0, '0},
			'{OP_QUERY, 17'd0,     16'd32768, 0, '0},
			'{OP_FREE,  17'd0,     16'd16,    0, '0},
			'{OP_QUERY, 17'd0,     16'd128,   0, '0},
			'{OP_FREE,  17'd0,     16'd32,    0, '0},
			'{OP_ALLOC, 17'd65535, 16'hAAAA,  0, '0},
			'{OP_FREE,  17'd0,     16'hFFF0,  0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_request(rows[i].op, rows[i].req, rows[i].off, rows[i].typed, rows[i].res);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				s_tvalid = 1'b0;
				wait (pending_results.size() == 0);
				@(negedge clk);
			end
			pick = $urandom_range(0, 99);
			req = 17'($urandom_range(0, 300));
			off = 16'($urandom);
			if (pick < 45) begin
				op = OP_ALLOC;
				if ($urandom_range(0, 9) == 0)
					req = 17'($urandom);
				else if ($urandom_range(0, 4) == 0)
					req = 17'($urandom_range(0, 8192));
			end else if (pick < 85 && live_blocks.size() > 0) begin
				op = (pick < 72) ? OP_FREE : OP_QUERY;
				off = 16'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
				if ($urandom_range(0, 15) == 0)
					off = off + 16'($urandom_range(1, 15));
			end else begin
				op = op_t'($urandom_range(0, 3));
				req = 17'($urandom);
			end
			send_request(op, req, off, 0, '0);
		end
		s_tvalid = 1'b0;

		wait (pending_results.size() == 0);
		wait_cnt = 0;
		while (wait_cnt < 400) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
